// ===== rtl/jsu_pkg.sv =====
// Package for the JSON string unescape unit: decoder state, result type,
// character codes and the hex digit helper. No dependencies.

package jsu_pkg;

    // Decoder mode between characters.
    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_ESCAPE  = 2'd1,
        MODE_HEX     = 2'd2,
        MODE_SWALLOW = 2'd3
    } t_mode;

    // Three hex digits are held while the fourth is awaited.
    localparam int unsigned CP_HELD_W = 12;

    typedef struct packed {
        t_mode                  mode;
        logic [1:0]             hex_cnt;
        logic [CP_HELD_W-1:0]   code_point;
    } t_state;

    typedef struct packed {
        logic [7:0] data;
        logic       status;
        logic       last;
    } t_result;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_HT = 8'h09;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_SUBST = 8'hFF;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Returns {valid, value} for one ASCII hex digit of either case.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== rtl/jsu_in_if.sv =====
// Input channel of the JSON string unescape unit: valid/ready plus one raw
// string body character. Depends on nothing.

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink (input valid, input in_char, input in_last, output ready);
endinterface

// ===== rtl/jsu_out_if.sv =====
// Output channel of the JSON string unescape unit: valid/ready plus one
// decoded byte with status and last flag. Depends on nothing.

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_status;
    logic       out_last;

    modport source (output valid, output out_byte, output out_status, output out_last,
                    input ready);
    modport sink (input valid, input out_byte, input out_status, input out_last,
                  output ready);
endinterface

// ===== rtl/json_string_unescape_unit.sv =====
// Top level of the JSON string unescape unit: input register, decoder and
// result register. Depends on jsu_pkg, jsu_in_if, jsu_out_if and jsu_decoder.

// The unit decodes the body of a JSON string, one raw character per input
// transaction with in_last on the final one, and gives at most one result
// transaction per character: the decoded byte, a status and a last flag.
// Characters inside an open escape give no result; a \uXXXX escape gives its
// byte when the code point lies strictly between 0x00 and 0xFF and 0xFF
// otherwise. An unknown escape, a bad hex digit or a string that ends inside
// an escape gives one error result (byte 0, status 1, last 1), and the rest of
// that string is dropped up to and including its last character. Throughput
// is one character per clock while the output does not stall it: each accepted
// character waits in the input register, is decoded combinationally by
// jsu_decoder against the escape state, and its result lands in the output
// register. The input side keeps accepting while a result waits in the output
// register, and stalls only when both registers hold work that cannot move.

module json_string_unescape_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    jsu_in_if.sink           i_in,
    jsu_out_if.source        o_out
);

    // Input register holding the next character to decode.
    logic             r_in_valid;
    logic [7:0]       r_in_char;
    logic             r_in_last;

    // Escape state, updated as each character leaves the input register.
    jsu_pkg::t_state  r_state;
    jsu_pkg::t_state  n_state;

    // Result register facing the output channel.
    logic             r_out_valid;
    jsu_pkg::t_result r_out;

    logic             w_res_valid;
    jsu_pkg::t_result w_res;
    logic             w_out_free;
    logic             w_adv;

    jsu_decoder u_decoder (
        .i_char      (r_in_char),
        .i_last      (r_in_last),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // The result register can take a new result when empty or being drained.
    assign w_out_free = !r_out_valid || o_out.ready;
    // A character leaves the input register when its result, if any, has room.
    assign w_adv      = r_in_valid && (w_out_free || !w_res_valid);
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{mode: jsu_pkg::MODE_NORMAL, hex_cnt: 2'd0, code_point: '0};
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_state <= n_state;
            end
            if (w_adv && w_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_char <= i_in.in_char;
            r_in_last <= i_in.in_last;
        end
        if (w_adv && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out.data;
    assign o_out.out_status = r_out.status;
    assign o_out.out_last   = r_out.last;

    // Reset empties both registers.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("registers not empty after reset");

    // Characters dropped after an error never produce a result.
    a_swallow_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_state.mode == jsu_pkg::MODE_SWALLOW |-> !w_res_valid)
        else $error("result produced while dropping an errored string");

    // An error result always closes the run and carries a zero byte.
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_res_valid && w_res.status == jsu_pkg::STATUS_ERR
        |=> r_out_valid && r_out.last && r_out.data == jsu_pkg::BYTE_ZERO)
        else $error("malformed error result");

    // Hex digit tracking is clear outside a unicode escape.
    a_hex_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mode != jsu_pkg::MODE_HEX |-> r_state.hex_cnt == 2'd0
        && r_state.code_point == '0)
        else $error("hex state left over outside unicode escape");

    // A waiting result is not overwritten while the output is stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !(w_adv && w_res_valid))
        else $error("pending result overwritten");

endmodule

// ===== rtl/jsu_decoder.sv =====
// Next-state and result logic of the JSON string unescape unit for one character.
// Depends on jsu_pkg.

module jsu_decoder (
    input  logic [7:0]      i_char,
    input  logic            i_last,
    input  jsu_pkg::t_state i_state,
    output jsu_pkg::t_state o_state,
    output logic            o_res_valid,
    output jsu_pkg::t_result o_res
);

    always_comb begin
        logic        fail;
        logic [4:0]  hex;
        logic [15:0] cp;

        fail        = 1'b0;
        hex         = jsu_pkg::hex_digit(i_char);
        cp          = {i_state.code_point, hex[3:0]};
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res.data  = i_char;
        o_res.status = jsu_pkg::STATUS_OK;
        o_res.last  = i_last;

        case (i_state.mode)
            jsu_pkg::MODE_NORMAL: begin
                if (i_char == jsu_pkg::CH_BSLASH) begin
                    if (i_last) begin
                        fail = 1'b1;
                    end else begin
                        o_state.mode = jsu_pkg::MODE_ESCAPE;
                    end
                end else begin
                    o_res_valid = 1'b1;
                end
            end
            jsu_pkg::MODE_ESCAPE: begin
                o_res_valid  = 1'b1;
                o_state.mode = jsu_pkg::MODE_NORMAL;
                case (i_char)
                    jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: begin
                        o_res.data = i_char;
                    end
                    jsu_pkg::CH_B: o_res.data = jsu_pkg::CTL_BS;
                    jsu_pkg::CH_F: o_res.data = jsu_pkg::CTL_FF;
                    jsu_pkg::CH_N: o_res.data = jsu_pkg::CTL_LF;
                    jsu_pkg::CH_R: o_res.data = jsu_pkg::CTL_CR;
                    jsu_pkg::CH_T: o_res.data = jsu_pkg::CTL_HT;
                    jsu_pkg::CH_U: begin
                        o_res_valid = 1'b0;
                        if (i_last) begin
                            fail = 1'b1;
                        end else begin
                            o_state.mode       = jsu_pkg::MODE_HEX;
                            o_state.hex_cnt    = 2'd0;
                            o_state.code_point = '0;
                        end
                    end
                    default: fail = 1'b1;
                endcase
            end
            jsu_pkg::MODE_HEX: begin
                if (!hex[4]) begin
                    fail = 1'b1;
                end else if (i_state.hex_cnt == 2'd3) begin
                    o_res_valid        = 1'b1;
                    o_state.mode       = jsu_pkg::MODE_NORMAL;
                    o_state.hex_cnt    = 2'd0;
                    o_state.code_point = '0;
                    // Only code points strictly between 0x00 and 0xFF pass as bytes.
                    if (cp[15:8] == 8'd0 && cp[7:0] != jsu_pkg::BYTE_ZERO
                            && cp[7:0] != jsu_pkg::BYTE_SUBST) begin
                        o_res.data = cp[7:0];
                    end else begin
                        o_res.data = jsu_pkg::BYTE_SUBST;
                    end
                end else if (i_last) begin
                    fail = 1'b1;
                end else begin
                    o_state.code_point = cp[jsu_pkg::CP_HELD_W-1:0];
                    o_state.hex_cnt    = i_state.hex_cnt + 2'd1;
                end
            end
            jsu_pkg::MODE_SWALLOW: begin
                if (i_last) begin
                    o_state.mode       = jsu_pkg::MODE_NORMAL;
                    o_state.hex_cnt    = 2'd0;
                    o_state.code_point = '0;
                end
            end
            default: o_state = i_state;
        endcase

        if (fail) begin
            o_res_valid        = 1'b1;
            o_res.data         = jsu_pkg::BYTE_ZERO;
            o_res.status       = jsu_pkg::STATUS_ERR;
            o_res.last         = 1'b1;
            o_state.mode       = i_last ? jsu_pkg::MODE_NORMAL : jsu_pkg::MODE_SWALLOW;
            o_state.hex_cnt    = 2'd0;
            o_state.code_point = '0;
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for json_string_unescape_unit: drives string bodies,
// predicts the decoded transactions and checks every result against them.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if and the unit itself.

module testbench;
    import jsu_pkg::*;

    // The slowest correct run stays far below this. That run has about 1600
    // characters, idle gaps on both sides and one long receiver hold-off.
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned HOLD_CYCLES  = 400;
    // The unit has only an input and an output register, so this drain margin is generous.
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned IDLE_PCT     = 37;
    localparam int unsigned MAX_REPORTS  = 40;

    localparam logic [7:0] SIMPLE_ESC [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                             CH_F, CH_N, CH_R, CH_T};

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the escape state machine of the unit. It queues
    // the decoded byte, if any, that each accepted character must produce, and it
    // compares each output transaction against the oldest queued entry.
    // ------------------------------------------------------------------
    class unescape_scoreboard;
        t_mode       mode;
        logic [1:0]  digits_taken;
        logic [15:0] code_acc;
        t_result     decoded_q[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned error_results;

        function new();
            mode         = MODE_NORMAL;
            digits_taken = 2'd0;
            code_acc     = 16'd0;
            mismatches   = 0;
            checked      = 0;
            error_results = 0;
        endfunction

        // Returns {is_hex, value} for one ASCII character.
        static function logic [4:0] hex_nibble(input logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39) begin
                return {1'b1, 4'(c - 8'h30)};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                return {1'b1, 4'(c - 8'h41 + 8'd10)};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                return {1'b1, 4'(c - 8'h61 + 8'd10)};
            end
            return 5'd0;
        endfunction

        function void queue_byte(input logic [7:0] b, input logic st, input logic l);
            t_result r;
            r.data   = b;
            r.status = st;
            r.last   = l;
            decoded_q.push_back(r);
        endfunction

        // An error ends the escape. The rest of the string is dropped unless
        // the error came on its final character.
        function void abort_escape(input logic l);
            mode         = l ? MODE_NORMAL : MODE_SWALLOW;
            digits_taken = 2'd0;
            code_acc     = 16'd0;
            queue_byte(BYTE_ZERO, STATUS_ERR, 1'b1);
        endfunction

        // Notes one accepted input transaction. Returns 0 when the character
        // fell into the dropped tail after an error.
        function bit note_char(input logic [7:0] c, input logic l);
            logic [4:0]  nib;
            logic [15:0] cp;
            case (mode)
                MODE_NORMAL: begin
                    if (c == CH_BSLASH) begin
                        if (l) abort_escape(1'b1);
                        else mode = MODE_ESCAPE;
                    end else begin
                        queue_byte(c, STATUS_OK, l);
                    end
                end
                MODE_ESCAPE: begin
                    mode = MODE_NORMAL;
                    case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: queue_byte(c, STATUS_OK, l);
                        CH_B: queue_byte(CTL_BS, STATUS_OK, l);
                        CH_F: queue_byte(CTL_FF, STATUS_OK, l);
                        CH_N: queue_byte(CTL_LF, STATUS_OK, l);
                        CH_R: queue_byte(CTL_CR, STATUS_OK, l);
                        CH_T: queue_byte(CTL_HT, STATUS_OK, l);
                        CH_U: begin
                            if (l) begin
                                abort_escape(1'b1);
                            end else begin
                                mode         = MODE_HEX;
                                digits_taken = 2'd0;
                                code_acc     = 16'd0;
                            end
                        end
                        default: abort_escape(l);
                    endcase
                end
                MODE_HEX: begin
                    nib = hex_nibble(c);
                    if (!nib[4]) begin
                        abort_escape(l);
                    end else begin
                        cp = {code_acc[11:0], nib[3:0]};
                        if (digits_taken == 2'd3) begin
                            // Only code points strictly inside 0x00..0xFF fit.
                            queue_byte((cp > 16'h0000 && cp < 16'h00FF) ? cp[7:0] : BYTE_SUBST,
                                       STATUS_OK, l);
                            mode         = MODE_NORMAL;
                            digits_taken = 2'd0;
                            code_acc     = 16'd0;
                        end else if (l) begin
                            abort_escape(1'b1);
                        end else begin
                            code_acc     = cp;
                            digits_taken = digits_taken + 2'd1;
                        end
                    end
                end
                default: begin
                    if (l) begin
                        mode         = MODE_NORMAL;
                        digits_taken = 2'd0;
                        code_acc     = 16'd0;
                    end
                    return 1'b0;
                end
            endcase
            return 1'b1;
        endfunction

        function void check_result(input t_result got);
            t_result want;
            if (decoded_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result data=%h status=%b last=%b",
                             $time, got.data, got.status, got.last);
                return;
            end
            want = decoded_q.pop_front();
            checked++;
            if (got.status == STATUS_ERR) error_results++;
            if (got.data !== want.data || got.status !== want.status
                    || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: mismatch expected data=%h status=%b last=%b, got data=%h status=%b last=%b",
                             $time, want.data, want.status, want.last,
                             got.data, got.status, got.last);
            end
        endfunction

        function int unsigned pending();
            return decoded_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    json_string_unescape_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    unescape_scoreboard sb = new();

    // Both sides idle at random while this is set. The middle of the random
    // part clears it to give one long stretch at full rate.
    bit          gaps_on = 1'b0;
    bit          hold_request = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned items_sent = 0;
    int unsigned live_items = 0;
    int unsigned strings_sent = 0;
    int unsigned cycle_count = 0;
    logic [7:0]  body[$];

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog. A hang anywhere in the run ends up here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still awaited.",
                     cycle_count, sb.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver. It samples output transactions at the rising edge and moves
    // ready at the falling edge. A hold-off request keeps ready low for a
    // long stretch that this process counts itself. During that stretch the
    // sender keeps offering characters until the unit backs up its input.
    initial begin
        int unsigned hold_left;
        t_result     got;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.data   = out_ch.out_byte;
                got.status = out_ch.out_status;
                got.last   = out_ch.out_last;
                sb.check_result(got);
            end
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (gaps_on) begin
                out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Offers one character and returns at the falling edge after the input
    // transaction. Valid only drops during an idle gap, so it never falls and
    // rises again within one time step.
    task automatic send_char(input logic [7:0] c, input logic l);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_char <= c;
        in_ch.in_last <= l;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        if (sb.note_char(c, l)) live_items++;
        items_sent++;
        @(negedge clk);
    endtask

    // Sends the body held in the queue, with in_last on its final character.
    task automatic send_body();
        for (int i = 0; i < body.size(); i++) begin
            send_char(body[i], i == body.size() - 1);
        end
        if (body.size() != 0) strings_sent++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] random_hex_char();
        return hex_char(4'($urandom_range(15)), $urandom_range(1));
    endfunction

    // Builds one random string body. Most bodies are well formed: plain
    // characters, simple escapes and \u escapes. About one in ten also
    // carries a broken escape. That escape is an unknown character or a bad hex
    // digit, which may leave a tail that gets dropped, or an escape cut off
    // at the end of the body.
    task automatic build_body();
        int unsigned n_tokens;
        int unsigned kind;
        int unsigned n_digits;
        logic [7:0]  c;
        logic [15:0] cp;
        body.delete();
        n_tokens = $urandom_range(1, 10);
        for (int t = 0; t < n_tokens; t++) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                do begin
                    c = ($urandom_range(99) < 70) ? 8'($urandom_range(8'h20, 8'h7E))
                                                  : 8'($urandom_range(255));
                end while (c == CH_BSLASH);
                body.push_back(c);
            end else if (kind < 80) begin
                body.push_back(CH_BSLASH);
                body.push_back(SIMPLE_ESC[$urandom_range(7)]);
            end else begin
                case ($urandom_range(9))
                    0: cp = 16'h0000;
                    1: cp = 16'h00FF;
                    2: cp = 16'h0001;
                    3, 4, 5: cp = 16'($urandom_range(8'hFF));
                    default: cp = 16'($urandom_range(16'hFFFF));
                endcase
                body.push_back(CH_BSLASH);
                body.push_back(CH_U);
                for (int d = 3; d >= 0; d--) begin
                    body.push_back(hex_char(cp[4*d +: 4], $urandom_range(1)));
                end
            end
        end
        if ($urandom_range(99) < 10) begin
            body.push_back(CH_BSLASH);
            case ($urandom_range(2))
                0: begin
                    do begin
                        c = 8'($urandom_range(255));
                    end while (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F,
                                         CH_N, CH_R, CH_T, CH_U});
                    body.push_back(c);
                end
                1: begin
                    body.push_back(CH_U);
                    n_digits = $urandom_range(3);
                    repeat (n_digits) body.push_back(random_hex_char());
                    do begin
                        c = 8'($urandom_range(255));
                    end while (unescape_scoreboard::hex_nibble(c) >= 5'h10);
                    body.push_back(c);
                end
                default: begin
                    // Cut off after the backslash, after the u, or inside the
                    // digits. No characters follow the cut.
                    n_digits = $urandom_range(4);
                    if (n_digits > 0) begin
                        body.push_back(CH_U);
                        repeat (n_digits - 1) body.push_back(random_hex_char());
                    end
                    return;
                end
            endcase
            // The tail after the error may hold anything, backslashes too.
            repeat ($urandom_range(4)) body.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic load_body(input logic [7:0] chars[$]);
        body = chars;
    endtask

    initial begin
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_char = 8'h00;
        in_ch.in_last = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, run without idle gaps. It covers both byte extremes
        // around every simple escape, a \u escape, an unknown escape with a
        // dropped tail, and a body cut off right after a backslash.
        load_body('{8'h00, CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_BSLASH, CH_BSLASH, CH_SLASH,
                    CH_BSLASH, CH_B, CH_BSLASH, CH_F, CH_BSLASH, CH_N, CH_BSLASH, CH_R,
                    CH_BSLASH, CH_T, 8'hFF});
        send_body();
        load_body('{CH_BSLASH, CH_U, 8'h30, 8'h30, 8'h34, 8'h31});
        send_body();
        load_body('{CH_BSLASH, 8'h71, 8'h5A});
        send_body();
        load_body('{CH_BSLASH});
        send_body();

        // Random part. Idle gaps run on both sides, except for a long stretch
        // in the middle. The receiver is held off once so that the unit fills.
        gaps_on = 1'b1;
        while (live_items < RANDOM_ITEMS + 28) begin
            gaps_on = !(live_items >= 700 && live_items < 1000);
            if (!hold_done && live_items >= 400) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            build_body();
            send_body();
        end
        in_ch.valid <= 1'b0;
        gaps_on = 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d string bodies with %0d characters (%0d outside dropped tails).",
                 strings_sent, items_sent, live_items);
        $display("Checked %0d decoded results, %0d of them error results; %0d mismatches.",
                 sb.checked, sb.error_results, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
